// File: design/dag_edge_move_proposer_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the DAG edge move proposer
// Shared helpers for concurrent checks on clk with a synchronous reset.
// ---------------------------------------------------------------------------
`ifndef DAG_EDGE_MOVE_PROPOSER_ASSERT_SVH
`define DAG_EDGE_MOVE_PROPOSER_ASSERT_SVH

// Check a property outside reset
`define DEMP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");

// Check a property at every edge, reset included
`define DEMP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`endif

// File: design/demp_pkg.sv
// ---------------------------------------------------------------------------
// demp_pkg
// Types, constants and the controller/datapath interface of the proposer.
// ---------------------------------------------------------------------------
package demp_pkg;

  localparam int NODES     = 32;
  localparam int IDX_W     = $clog2(NODES);
  localparam int CNT_W     = $clog2(NODES + 1);
  localparam int NODE_W    = 5;
  localparam int RAND_W    = 16;
  localparam int WEIGHT_W  = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;

  // request types
  localparam logic [1:0] REQ_EDGE = 2'd0;
  localparam logic [1:0] REQ_SLOT = 2'd1;
  localparam logic [1:0] REQ_PROP = 2'd2;
  localparam logic [1:0] REQ_RSVD = 2'd3;

  // move kinds
  localparam logic [1:0] KIND_ADD  = 2'd0;
  localparam logic [1:0] KIND_REM  = 2'd1;
  localparam logic [1:0] KIND_SWAP = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_NODES   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PARENTS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_W_ADD       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_W_REM       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_W_SWAP      = 3'd4;

  // bit vector sources for the pick and scan unit
  localparam logic [1:0] SRC_ELIG = 2'd0;
  localparam logic [1:0] SRC_ROW  = 2'd1;
  localparam logic [1:0] SRC_CAND = 2'd2;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic              edge_value;
    logic [RAND_W-1:0] rand_0;
    logic [RAND_W-1:0] rand_1;
    logic [RAND_W-1:0] rand_2;
    logic [RAND_W-1:0] rand_3;
  } req_t;

  typedef struct packed {
    logic              success;
    logic [1:0]        move_kind;
    logic [NODE_W-1:0] child_node;
    logic [NODE_W-1:0] added_parent;
    logic [NODE_W-1:0] removed_parent;
  } res_t;

  typedef struct packed {
    logic       cap;
    logic       do_write;
    logic       res_fail;
    logic       res_move;
    logic       out_load;
    logic       kind_zero;
    logic       kmul;
    logic       kcmp;
    logic       next_try;
    logic       elig_step;
    logic       pick;
    logic [1:0] pick_src;
    logic       scan_step;
    logic [1:0] scan_src;
    logic       load_child;
  } cmd_t;

  typedef struct packed {
    logic       is_prop;
    logic       n_zero;
    logic       total_zero;
    logic       cnt_last;
    logic       m_zero;
    logic       found;
    logic [1:0] kind;
    logic       attempt_last;
    logic       out_stall;
  } sts_t;

endpackage

// File: design/demp_datapath.sv
// ---------------------------------------------------------------------------
// demp_datapath
// Graph state, configuration, eligibility unit, pick and bit scan unit and
// the output register.
// ---------------------------------------------------------------------------
module demp_datapath import demp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  req_t                 in_data,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output res_t                 out_data,
  input  cmd_t                 cmd,
  output sts_t                 sts
);

  logic [5:0]          num_nodes;
  logic [5:0]          max_parents;
  logic [WEIGHT_W-1:0] w_add, w_rem, w_swap;

  logic [NODES-1:0] parent_bits   [NODES];
  logic [IDX_W-1:0] order_node    [NODES];
  logic [IDX_W-1:0] node_position [NODES];

  req_t                req;
  logic [2:0]          draw_ptr;
  logic [33:0]         prod_k;
  logic [1:0]          chosen, attempt, kind;
  logic [CNT_W-1:0]    m_cnt, scan_cnt, target, np_r, nc_r;
  logic [NODES-1:0]    elig, row_v, cand_v;
  logic [IDX_W-1:0]    scan_idx, child, addp, remp;
  res_t                res_pend;
  res_t                wr_res;

  logic [CNT_W-1:0]    n_act;
  logic [NODES-1:0]    nmask, slot_ok;
  logic [IDX_W-1:0]    eval_idx, pos;
  logic [NODES-1:0]    e_row, e_cand;
  logic [CNT_W-1:0]    e_np, e_nc;
  logic                elig_now;
  logic [RAND_W-1:0]   u;
  logic [17:0]         total;
  logic [CNT_W-1:0]    pick_m, pidx, pick_val;
  logic [RAND_W+CNT_W-1:0] prod_p;
  logic [NODES-1:0]    scan_vec;
  logic                found;
  logic                wr_ok;

  // active node count, limited to the array size
  assign n_act = (int'(num_nodes) > NODES) ? CNT_W'(NODES) : CNT_W'(num_nodes);

  always_comb begin
    for (int q = 0; q < NODES; q++) begin
      nmask[q]   = q < int'(n_act);
      slot_ok[q] = int'(order_node[q]) < int'(n_act);
    end
  end

  // eligibility of one child per cycle
  assign eval_idx = cmd.load_child ? child : scan_idx;
  assign pos      = node_position[eval_idx];
  assign e_row    = parent_bits[eval_idx] & nmask;

  always_comb begin
    for (int p = 0; p < NODES; p++) begin
      e_cand[p] = (p < int'(pos)) && (p < int'(n_act)) && slot_ok[p] &&
                  !e_row[order_node[p]];
    end
  end

  assign e_np = CNT_W'($countones(e_row));
  assign e_nc = CNT_W'($countones(e_cand));

  always_comb begin
    unique case (kind)
      KIND_ADD: elig_now = (e_np < CNT_W'(max_parents)) && (|e_cand);
      KIND_REM: elig_now = (e_np != '0);
      default:  elig_now = (e_np != '0) && (|e_cand);
    endcase
  end

  // fallback order: chosen kind first, then the rest in add, remove, swap order
  always_comb begin
    unique case (attempt)
      2'd0:    kind = chosen;
      2'd1:    kind = (chosen == KIND_ADD) ? KIND_REM : KIND_ADD;
      default: kind = (chosen == KIND_SWAP) ? KIND_REM : KIND_SWAP;
    endcase
  end

  // current draw
  always_comb begin
    unique case (draw_ptr[1:0])
      2'd0:    u = req.rand_0;
      2'd1:    u = req.rand_1;
      2'd2:    u = req.rand_2;
      default: u = req.rand_3;
    endcase
  end

  assign total = 18'(w_add) + 18'(w_rem) + 18'(w_swap);

  // pick: floor(u*m) in Q0.16, clamped below m
  always_comb begin
    unique case (cmd.pick_src)
      SRC_ELIG: pick_m = m_cnt;
      SRC_ROW:  pick_m = np_r;
      default:  pick_m = nc_r;
    endcase
  end

  assign prod_p   = (RAND_W + CNT_W)'(u) * (RAND_W + CNT_W)'(pick_m);
  assign pidx     = prod_p[RAND_W+CNT_W-1:RAND_W];
  assign pick_val = (pidx >= pick_m) ? pick_m - CNT_W'(1) : pidx;

  // scan for the target-th set bit
  always_comb begin
    unique case (cmd.scan_src)
      SRC_ELIG: scan_vec = elig;
      SRC_ROW:  scan_vec = row_v;
      default:  scan_vec = cand_v;
    endcase
  end

  assign found = scan_vec[scan_idx] && (scan_cnt == target);
  assign wr_ok = (int'(req.node_a) < NODES) && (int'(req.node_b) < NODES);

  // result of a write request: only success may be set
  always_comb begin
    wr_res         = '0;
    wr_res.success = wr_ok && (req.req_type != REQ_RSVD);
  end

  // status to the controller
  always_comb begin
    sts.is_prop      = req.req_type == REQ_PROP;
    sts.n_zero       = n_act == '0;
    sts.total_zero   = total == '0;
    sts.cnt_last     = (CNT_W'(scan_idx) + CNT_W'(1)) == n_act;
    sts.m_zero       = m_cnt == '0;
    sts.found        = found;
    sts.kind         = kind;
    sts.attempt_last = attempt == 2'd2;
    sts.out_stall    = out_valid && !out_ready;
  end

  // configuration and graph state
  always_ff @(posedge clk) begin
    if (rst) begin
      num_nodes   <= 6'(NODES);
      max_parents <= 6'd4;
      w_add       <= 16'd21845;
      w_rem       <= 16'd21845;
      w_swap      <= 16'd21845;
      for (int i = 0; i < NODES; i++) begin
        parent_bits[i]   <= '0;
        order_node[i]    <= IDX_W'(i);
        node_position[i] <= IDX_W'(i);
      end
    end else begin
      if (cfg_valid) begin
        priority case (cfg_index)
          CFG_NUM_NODES:   num_nodes   <= cfg_data[5:0];
          CFG_MAX_PARENTS: max_parents <= cfg_data[5:0];
          CFG_W_ADD:       w_add       <= cfg_data;
          CFG_W_REM:       w_rem       <= cfg_data;
          CFG_W_SWAP:      w_swap      <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.do_write && wr_ok) begin
        if (req.req_type == REQ_EDGE) begin
          parent_bits[IDX_W'(req.node_a)][IDX_W'(req.node_b)] <= req.edge_value;
        end else if (req.req_type == REQ_SLOT) begin
          order_node[IDX_W'(req.node_a)]    <= IDX_W'(req.node_b);
          node_position[IDX_W'(req.node_b)] <= IDX_W'(req.node_a);
        end
      end
    end
  end

  // proposal working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      draw_ptr <= '0;
      chosen   <= KIND_ADD;
      attempt  <= '0;
      m_cnt    <= '0;
      scan_idx <= '0;
      scan_cnt <= '0;
    end else begin
      if (cmd.cap) begin
        req      <= in_data;
        draw_ptr <= '0;
        child    <= '0;
        addp     <= '0;
        remp     <= '0;
      end
      if (cmd.kmul) begin
        prod_k <= 34'(u) * 34'(total);
        if (draw_ptr < 3'd4) draw_ptr <= draw_ptr + 3'd1;
      end
      if (cmd.kcmp || cmd.kind_zero || cmd.next_try) begin
        m_cnt    <= '0;
        scan_idx <= '0;
      end
      if (cmd.kcmp) begin
        attempt <= '0;
        if (prod_k < {w_add, 16'd0}) chosen <= KIND_ADD;
        else if (prod_k < {1'b0, 17'(w_add) + 17'(w_rem), 16'd0}) chosen <= KIND_REM;
        else chosen <= KIND_SWAP;
      end
      if (cmd.kind_zero) begin
        attempt <= '0;
        chosen  <= KIND_ADD;
      end
      if (cmd.next_try) attempt <= attempt + 2'd1;
      if (cmd.elig_step) begin
        elig[scan_idx] <= elig_now;
        if (elig_now) m_cnt <= m_cnt + CNT_W'(1);
        scan_idx <= scan_idx + IDX_W'(1);
      end
      if (cmd.pick) begin
        target   <= pick_val;
        scan_idx <= '0;
        scan_cnt <= '0;
        if (draw_ptr < 3'd4) draw_ptr <= draw_ptr + 3'd1;
      end
      if (cmd.scan_step) begin
        scan_idx <= scan_idx + IDX_W'(1);
        if (scan_vec[scan_idx]) begin
          if (found) begin
            unique case (cmd.scan_src)
              SRC_ELIG: child <= scan_idx;
              SRC_ROW:  remp  <= scan_idx;
              default:  addp  <= order_node[scan_idx];
            endcase
          end else begin
            scan_cnt <= scan_cnt + CNT_W'(1);
          end
        end
      end
      if (cmd.load_child) begin
        row_v  <= e_row;
        cand_v <= e_cand;
        np_r   <= e_np;
        nc_r   <= e_nc;
      end
    end
  end

  // pending result and output register
  always_ff @(posedge clk) begin
    if (cmd.do_write) begin
      res_pend <= wr_res;
    end else if (cmd.res_fail) begin
      res_pend <= '0;
    end else if (cmd.res_move) begin
      res_pend.success        <= 1'b1;
      res_pend.move_kind      <= kind;
      res_pend.child_node     <= NODE_W'(child);
      res_pend.added_parent   <= NODE_W'(addp);
      res_pend.removed_parent <= NODE_W'(remp);
    end
    if (cmd.out_load) out_data <= res_pend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: design/demp_ctrl.sv
// ---------------------------------------------------------------------------
// demp_ctrl
// Sequencer for writes and proposals: kind draw, eligibility pass, picks
// and bit scans, result hand-off.
// ---------------------------------------------------------------------------
module demp_ctrl import demp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_KMUL   = 4'd2;
  localparam logic [3:0] S_KCMP   = 4'd3;
  localparam logic [3:0] S_CNT    = 4'd4;
  localparam logic [3:0] S_CHKM   = 4'd5;
  localparam logic [3:0] S_SCHILD = 4'd6;
  localparam logic [3:0] S_LOAD   = 4'd7;
  localparam logic [3:0] S_PREM   = 4'd8;
  localparam logic [3:0] S_SREM   = 4'd9;
  localparam logic [3:0] S_PADD   = 4'd10;
  localparam logic [3:0] S_SADD   = 4'd11;
  localparam logic [3:0] S_RES    = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  logic [3:0] state, state_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap    = 1'b1;
          state_next = S_DECODE;
        end
      end
      // writes finish here; proposals fail with no active nodes, skip the kind draw on a zero weight sum, else start it
      S_DECODE: begin
        if (!sts.is_prop) begin
          cmd.do_write = 1'b1;
          state_next   = S_DONE;
        end else if (sts.n_zero) begin
          cmd.res_fail = 1'b1;
          state_next   = S_DONE;
        end else if (sts.total_zero) begin
          cmd.kind_zero = 1'b1;
          state_next    = S_CNT;
        end else begin
          cmd.kmul   = 1'b1;
          state_next = S_KMUL;
        end
      end
      S_KMUL: state_next = S_KCMP;
      S_KCMP: begin
        cmd.kcmp   = 1'b1;
        state_next = S_CNT;
      end
      // one child per cycle
      S_CNT: begin
        cmd.elig_step = 1'b1;
        if (sts.cnt_last) state_next = S_CHKM;
      end
      S_CHKM: begin
        if (!sts.m_zero) begin
          cmd.pick     = 1'b1;
          cmd.pick_src = SRC_ELIG;
          state_next   = S_SCHILD;
        end else if (sts.attempt_last) begin
          cmd.res_fail = 1'b1;
          state_next   = S_DONE;
        end else begin
          cmd.next_try = 1'b1;
          state_next   = S_CNT;
        end
      end
      S_SCHILD: begin
        cmd.scan_step = 1'b1;
        cmd.scan_src  = SRC_ELIG;
        if (sts.found) state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_child = 1'b1;
        state_next     = (sts.kind == KIND_ADD) ? S_PADD : S_PREM;
      end
      S_PREM: begin
        cmd.pick     = 1'b1;
        cmd.pick_src = SRC_ROW;
        state_next   = S_SREM;
      end
      S_SREM: begin
        cmd.scan_step = 1'b1;
        cmd.scan_src  = SRC_ROW;
        if (sts.found) state_next = (sts.kind == KIND_REM) ? S_RES : S_PADD;
      end
      S_PADD: begin
        cmd.pick     = 1'b1;
        cmd.pick_src = SRC_CAND;
        state_next   = S_SADD;
      end
      S_SADD: begin
        cmd.scan_step = 1'b1;
        cmd.scan_src  = SRC_CAND;
        if (sts.found) state_next = S_RES;
      end
      S_RES: begin
        cmd.res_move = 1'b1;
        state_next   = S_DONE;
      end
      // hold the result until the output register frees
      S_DONE: begin
        if (!sts.out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: design/dag_edge_move_proposer.sv
// ---------------------------------------------------------------------------
// dag_edge_move_proposer
// Holds a DAG parent matrix and node ordering and proposes add, remove or
// swap moves. A write request is decoded, applied and passed to the output
// register. A proposal over n active nodes picks a kind, runs an eligibility
// pass over the n nodes for each kind tried, then up to three bit scans of
// at most NODES bits each and the result hand-off. The eligibility unit
// examines one child per cycle and the scan unit steps one bit per cycle.
// One request is in work at a time; a finished result waits in the
// output register while the next request is taken. No clearing pass
// follows reset.
// ---------------------------------------------------------------------------
module dag_edge_move_proposer import demp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  req_t                 in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output res_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  demp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  demp_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// File: design/demp_checker.sv
// ---------------------------------------------------------------------------
// demp_checker
// Port-level checks on the proposer, attached by bind.
// ---------------------------------------------------------------------------
`include "dag_edge_move_proposer_assert.svh"

module demp_checker import demp_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input req_t                 in_data,
  input logic                 out_valid,
  input logic                 out_ready,
  input res_t                 out_data,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [CFG_W-1:0]     cfg_data
);

  // one request in work: no accept right after an accept
  `DEMP_ASSERT(a_one_in_flight, clk, rst, (in_valid && in_ready) |=> !in_ready)

  // a stalled result holds
  `DEMP_ASSERT(a_out_hold, clk, rst,
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))

  // failed or ignored requests report all fields zero
  `DEMP_ASSERT(a_fail_zero, clk, rst,
    (out_valid && !out_data.success) |->
      (out_data.move_kind == '0 && out_data.child_node == '0 &&
       out_data.added_parent == '0 && out_data.removed_parent == '0))

  // configuration port never stalls
  `DEMP_ASSERT_ALWAYS(a_cfg_ready, clk, cfg_ready)

endmodule

bind dag_edge_move_proposer demp_checker u_demp_checker (.*);

// File: tb/tb.sv
// ---------------------------------------------------------------------------
// DAG edge move proposer testbench
// Drives edge, slot, propose and reserved requests with random handshake
// gaps, predicts every result from a local copy of the graph, ordering and
// registers, and compares each result field by field in arrival order.
// ---------------------------------------------------------------------------
module tb;
  import demp_pkg::*;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  req_t                 in_data;
  logic                 out_valid;
  logic                 out_ready;
  res_t                 out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  dag_edge_move_proposer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow of the graph, ordering and registers
  logic [31:0] row_sh [NODES];
  logic [4:0]  slot_sh [NODES];
  logic [4:0]  pos_sh [NODES];
  int unsigned nn_sh, maxp_sh, wa_sh, wr_sh, ws_sh;
  logic [15:0] draw_q [4];
  int unsigned draw_ptr;

  res_t        expected_q [$];
  int          fail_cnt = 0;
  longint      cycle_cnt = 0;
  int unsigned out_wait;

  always begin
    clk = 1'b0; #1;
    clk = 1'b1; #1;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 64'd3000000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int unsigned next_u();
    int unsigned u;
    u = draw_q[draw_ptr];
    if (draw_ptr < 3) draw_ptr++;
    return u;
  endfunction

  function automatic int unsigned pick_idx(int unsigned m);
    longint unsigned v;
    v = (longint'(next_u()) * m) >> 16;
    if (v >= m) v = m - 1;
    return int'(v);
  endfunction

  function automatic logic [31:0] live_row(int unsigned c, int unsigned n);
    logic [31:0] mask;
    mask = (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 1);
    return row_sh[c] & mask;
  endfunction

  // Count candidates of c; the want-th one lands in found
  function automatic int unsigned cand_scan(int unsigned c, int unsigned n,
                                            int unsigned want,
                                            inout int unsigned found);
    int unsigned lim, k;
    logic [31:0] r;
    lim = pos_sh[c];
    k = 0;
    r = live_row(c, n);
    if (lim > n) lim = n;
    for (int unsigned p = 0; p < lim; p++) begin
      if (slot_sh[p] < n && !r[slot_sh[p]]) begin
        if (k == want) found = slot_sh[p];
        k++;
      end
    end
    return k;
  endfunction

  function automatic bit can_move(int unsigned kind, int unsigned c, int unsigned n);
    int unsigned np, dmy;
    np = $countones(live_row(c, n));
    dmy = 0;
    if (kind == KIND_ADD) return np < maxp_sh && cand_scan(c, n, 32'hFFFF_FFFF, dmy) > 0;
    if (kind == KIND_REM) return np > 0;
    return np > 0 && cand_scan(c, n, 32'hFFFF_FFFF, dmy) > 0;
  endfunction

  function automatic bit try_move(int unsigned kind, int unsigned n, inout res_t r);
    int unsigned m, sel, child, k, addp, remp, want, nc;
    logic [31:0] row;
    m = 0; child = 0; k = 0; addp = 0; remp = 0;
    for (int unsigned c = 0; c < n; c++) if (can_move(kind, c, n)) m++;
    if (m == 0) return 1'b0;
    sel = pick_idx(m);
    for (int unsigned c = 0; c < n; c++) begin
      if (can_move(kind, c, n)) begin
        if (k == sel) begin
          child = c;
          break;
        end
        k++;
      end
    end
    if (kind != KIND_ADD) begin
      row = live_row(child, n);
      want = pick_idx($countones(row));
      k = 0;
      for (int unsigned q = 0; q < n; q++) begin
        if (row[q]) begin
          if (k == want) begin
            remp = q;
            break;
          end
          k++;
        end
      end
    end
    if (kind != KIND_REM) begin
      nc = cand_scan(child, n, 32'hFFFF_FFFF, addp);
      void'(cand_scan(child, n, pick_idx(nc), addp));
    end
    r.success = 1'b1;
    r.move_kind = kind[1:0];
    r.child_node = child[4:0];
    r.added_parent = addp[4:0];
    r.removed_parent = remp[4:0];
    return 1'b1;
  endfunction

  // Predict one result and advance the shadow state
  function automatic res_t predict_move(req_t q);
    res_t r;
    int unsigned n, chosen;
    longint unsigned tot, x;
    r = '0;
    draw_q[0] = q.rand_0; draw_q[1] = q.rand_1;
    draw_q[2] = q.rand_2; draw_q[3] = q.rand_3;
    draw_ptr = 0;
    case (q.req_type)
      REQ_EDGE: begin
        row_sh[q.node_a][q.node_b] = q.edge_value;
        r.success = 1'b1;
      end
      REQ_SLOT: begin
        slot_sh[q.node_a] = q.node_b;
        pos_sh[q.node_b] = q.node_a;
        r.success = 1'b1;
      end
      REQ_PROP: begin
        n = (nn_sh > NODES) ? NODES : nn_sh;
        if (n == 0) return r;
        tot = longint'(wa_sh) + wr_sh + ws_sh;
        chosen = KIND_ADD;
        if (tot != 0) begin
          x = longint'(next_u()) * tot;
          if (x < (longint'(wa_sh) << 16)) chosen = KIND_ADD;
          else if (x < ((longint'(wa_sh) + wr_sh) << 16)) chosen = KIND_REM;
          else chosen = KIND_SWAP;
        end
        if (try_move(chosen, n, r)) return r;
        for (int unsigned i = 0; i < 3; i++) begin
          if (i != chosen && try_move(i, n, r)) return r;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Send one request and queue its expectation; valid stays up until the
  // next gap or the next settle
  task automatic send_req(req_t q);
    int unsigned gap;
    gap = $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    expected_q.push_back(predict_move(q));
    in_valid <= 1'b1;
    in_data  <= q;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid, let the queue drain, then wait out the block's longest latency
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[15:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_NUM_NODES:   nn_sh = val & 63;
      CFG_MAX_PARENTS: maxp_sh = val & 63;
      CFG_W_ADD:       wa_sh = val & 16'hFFFF;
      CFG_W_REM:       wr_sh = val & 16'hFFFF;
      CFG_W_SWAP:      ws_sh = val & 16'hFFFF;
      default: ;
    endcase
  endtask

  task automatic set_regs(int unsigned n, int unsigned mp, int unsigned a,
                          int unsigned rm, int unsigned s);
    settle();
    write_reg(CFG_NUM_NODES, n);
    write_reg(CFG_MAX_PARENTS, mp);
    write_reg(CFG_W_ADD, a);
    write_reg(CFG_W_REM, rm);
    write_reg(CFG_W_SWAP, s);
    cfg_valid <= 1'b0;
  endtask

  function automatic req_t rand_req(logic [1:0] kind, int unsigned n);
    req_t q;
    int unsigned hi;
    hi = (n == 0) ? 0 : ((n > 32) ? 31 : n - 1);
    q.req_type   = kind;
    q.node_a     = 5'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                  : $urandom_range(0, hi));
    q.node_b     = 5'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                  : $urandom_range(0, hi));
    q.edge_value = $urandom_range(0, 2) != 0;
    q.rand_0     = 16'($urandom_range(0, 65535));
    q.rand_1     = 16'($urandom_range(0, 65535));
    q.rand_2     = 16'($urandom_range(0, 65535));
    q.rand_3     = 16'($urandom_range(0, 65535));
    return q;
  endfunction

  function automatic req_t mk_req(logic [1:0] kind, int unsigned a, int unsigned b,
                                  bit v, int unsigned u);
    req_t q;
    q.req_type = kind;
    q.node_a = a[4:0];
    q.node_b = b[4:0];
    q.edge_value = v;
    q.rand_0 = u[15:0];
    q.rand_1 = u[15:0];
    q.rand_2 = 16'hFFFF - u[15:0];
    q.rand_3 = u[15:0];
    return q;
  endfunction

  // Result checker: compare against the oldest expectation, then hold ready
  // low for a freshly drawn number of cycles
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_wait = $urandom_range(0, 19);
    end else if (out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result %p", out_data);
        fail_cnt++;
      end else begin
        res_t e;
        e = expected_q.pop_front();
        if (out_data.success !== e.success) begin
          $error("success exp %0d got %0d", e.success, out_data.success); fail_cnt++;
        end
        if (out_data.move_kind !== e.move_kind) begin
          $error("move_kind exp %0d got %0d", e.move_kind, out_data.move_kind); fail_cnt++;
        end
        if (out_data.child_node !== e.child_node) begin
          $error("child_node exp %0d got %0d", e.child_node, out_data.child_node);
          fail_cnt++;
        end
        if (out_data.added_parent !== e.added_parent) begin
          $error("added_parent exp %0d got %0d", e.added_parent, out_data.added_parent);
          fail_cnt++;
        end
        if (out_data.removed_parent !== e.removed_parent) begin
          $error("removed_parent exp %0d got %0d", e.removed_parent,
                 out_data.removed_parent);
          fail_cnt++;
        end
      end
      out_wait = $urandom_range(0, 19);
      out_ready <= (out_wait == 0);
    end else if (!out_ready) begin
      if (out_wait <= 1) out_ready <= 1'b1;
      if (out_wait != 0) out_wait--;
    end
  end

  // Extremes of fields, every request type, zero weights, empty graph
  task automatic test_directed();
    send_req(mk_req(REQ_PROP, 0, 0, 0, 0));          // empty graph: adds a parent
    send_req(mk_req(REQ_EDGE, 31, 0, 1, 65535));
    send_req(mk_req(REQ_EDGE, 31, 31, 1, 0));
    send_req(mk_req(REQ_EDGE, 5, 2, 1, 0));
    send_req(mk_req(REQ_PROP, 0, 0, 0, 0));
    send_req(mk_req(REQ_PROP, 0, 0, 0, 65535));
    send_req(mk_req(REQ_PROP, 0, 0, 0, 32768));
    send_req(mk_req(REQ_RSVD, 31, 31, 1, 65535));    // unknown type ignored
    send_req(mk_req(REQ_SLOT, 0, 31, 0, 0));         // not a permutation
    send_req(mk_req(REQ_SLOT, 31, 0, 0, 0));
    send_req(mk_req(REQ_PROP, 0, 0, 0, 12345));
    send_req(mk_req(REQ_EDGE, 31, 31, 0, 0));
    set_regs(32, 0, 0, 0, 0);                         // zero weight sum
    send_req(mk_req(REQ_PROP, 0, 0, 0, 40000));
    set_regs(0, 32, 65535, 65535, 65535);             // no nodes
    send_req(mk_req(REQ_PROP, 0, 0, 0, 65535));
    set_regs(63, 63, 65535, 0, 0);                    // above NODES acts as NODES
    send_req(mk_req(REQ_PROP, 0, 0, 0, 1));
    set_regs(1, 1, 0, 65535, 0);
    send_req(mk_req(REQ_PROP, 0, 0, 0, 65535));
  endtask

  // Random requests under a given register setting
  task automatic test_random(int unsigned cnt);
    int unsigned sel;
    for (int unsigned i = 0; i < cnt; i++) begin
      sel = $urandom_range(0, 19);
      if (sel < 8)       send_req(rand_req(REQ_PROP, nn_sh));
      else if (sel < 15) send_req(rand_req(REQ_EDGE, nn_sh));
      else if (sel < 19) send_req(rand_req(REQ_SLOT, nn_sh));
      else               send_req(rand_req(REQ_RSVD, nn_sh));
    end
  endtask

  task automatic test_settings();
    set_regs(32, 4, 21845, 21845, 21845);
    test_random(300);
    set_regs(8, 2, 100, 65535, 1);
    test_random(250);
    set_regs(2, 1, 65535, 65535, 65535);
    test_random(150);
    set_regs(16, 32, 0, 0, 65535);
    test_random(250);
    set_regs(5, 3, $urandom_range(0, 65535), $urandom_range(0, 65535),
             $urandom_range(0, 65535));
    test_random(200);
    set_regs(32, 8, 1, 0, 0);
    test_random(150);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_NUM_NODES;
    cfg_data = '0;
    nn_sh = 32; maxp_sh = 4;
    wa_sh = 21845; wr_sh = 21845; ws_sh = 21845;
    for (int i = 0; i < NODES; i++) begin
      row_sh[i] = '0;
      slot_sh[i] = i[4:0];
      pos_sh[i] = i[4:0];
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_settings();
    settle();
    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
